### src/cmc_pkg.sv
// ----------------------------------------------------------------------------
// Color marker centroid package
// Shared sizes, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cmc_pkg;

    // Image and field sizes.
    localparam int IMG_DIM  = 256;
    localparam int POS_W    = 8;
    localparam int CHAN_W   = 8;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 17;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT = 1'd1;
    localparam logic [CFG_W-1:0]     DARK_RESET       = 8'd50;
    localparam logic [CFG_W-1:0]     BRIGHT_RESET     = 8'd200;

    // Mean division: one quotient bit per step, the mean is POS_W bits wide.
    localparam int DIV_STEPS = POS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int DVS_W     = CNT_W + DIV_STEPS - 1;

    // Accumulator lanes: start row, start col, end row, end col.
    localparam int N_LANES   = 4;
    localparam int N_MARKERS = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;   // add the accepted pixel to the accumulators
        logic load;     // copy sums into the divider and clear accumulators
        logic step;     // one restoring division step on every lane
        logic publish;  // write the means into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register can take a new result this cycle
    } t_dp_status;

endpackage

### src/cmc_ctrl.sv
// ----------------------------------------------------------------------------
// Color marker centroid controller
// Sequences pixel accumulation, mean division and result hand-off.
// ----------------------------------------------------------------------------
module cmc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_last,
    output logic                  o_stall,
    input  cmc_pkg::t_dp_status   i_status,
    output cmc_pkg::t_ctrl_cmd    o_cmd
);

    localparam logic [1:0] S_ACC  = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [cmc_pkg::STEP_W-1:0]  r_step, n_step;
    logic                        accept;

    // Pixels are taken only while accumulating.
    assign o_stall = (r_state != S_ACC);
    assign accept  = i_valid && !o_stall;

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_ACC: begin
                if (accept && i_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == cmc_pkg::STEP_W'(cmc_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.acc_en  = accept;
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.step    = (r_state == S_DIV);
        o_cmd.publish = (r_state == S_DONE) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### src/cmc_datapath.sv
// ----------------------------------------------------------------------------
// Color marker centroid datapath
// Pixel classification, sum/count accumulators, restoring mean dividers,
// limit registers and the output register.
// ----------------------------------------------------------------------------
module cmc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cmc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cmc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [cmc_pkg::CHAN_W-1:0]        i_blue,
    input  logic [cmc_pkg::CHAN_W-1:0]        i_green,
    input  logic [cmc_pkg::CHAN_W-1:0]        i_red,
    input  logic [cmc_pkg::POS_W-1:0]         i_row,
    input  logic [cmc_pkg::POS_W-1:0]         i_col,
    input  cmc_pkg::t_ctrl_cmd                i_cmd,
    output cmc_pkg::t_dp_status               o_status,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cmc_pkg::POS_W-1:0]         o_start_row,
    output logic [cmc_pkg::POS_W-1:0]         o_start_col,
    output logic                              o_start_found,
    output logic [cmc_pkg::POS_W-1:0]         o_end_row,
    output logic [cmc_pkg::POS_W-1:0]         o_end_col,
    output logic                              o_end_found
);

    localparam int LANES = cmc_pkg::N_LANES;
    localparam int MARKS = cmc_pkg::N_MARKERS;

    logic [cmc_pkg::CFG_W-1:0]   r_dark, r_bright;

    logic [cmc_pkg::SUM_W-1:0]   r_sum [LANES];
    logic [cmc_pkg::CNT_W-1:0]   r_cnt [MARKS];

    logic [cmc_pkg::SUM_W-1:0]   r_rem [LANES];
    logic [cmc_pkg::DVS_W-1:0]   r_dvs [MARKS];
    logic [cmc_pkg::POS_W-1:0]   r_quo [LANES];
    logic                        r_sat [LANES];
    logic                        r_found [MARKS];

    logic                        r_out_valid;
    logic [cmc_pkg::POS_W-1:0]   r_out_mean [LANES];
    logic                        r_out_found [MARKS];

    logic                        in_image, b_dark;
    logic                        hit [MARKS];
    logic [cmc_pkg::POS_W-1:0]   lane_pos [LANES];
    logic                        ge [LANES];
    logic [cmc_pkg::POS_W-1:0]   mean [LANES];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark   <= cmc_pkg::DARK_RESET;
            r_bright <= cmc_pkg::BRIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cmc_pkg::CFG_DARK_LIMIT) begin
                r_dark <= i_cfg_data;
            end
            if (i_cfg_idx == cmc_pkg::CFG_BRIGHT_LIMIT) begin
                r_bright <= i_cfg_data;
            end
        end
    end

    // Pixel classification; a pixel may meet both tests.
    always_comb begin
        in_image = ({1'b0, i_row} < (cmc_pkg::POS_W+1)'(cmc_pkg::IMG_DIM)) &&
                   ({1'b0, i_col} < (cmc_pkg::POS_W+1)'(cmc_pkg::IMG_DIM));
        b_dark = (i_blue < r_dark);
        hit[0] = in_image && b_dark && (i_green < r_dark) && (i_red > r_bright);
        hit[1] = in_image && b_dark && (i_red < r_dark) && (i_green > r_bright);
        lane_pos[0] = i_row;
        lane_pos[1] = i_col;
        lane_pos[2] = i_row;
        lane_pos[3] = i_col;
    end

    // Accumulators: cleared when their totals move into the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_sum[l] <= '0;
            end
            for (int m = 0; m < MARKS; m++) begin
                r_cnt[m] <= '0;
            end
        end else if (i_cmd.load) begin
            for (int l = 0; l < LANES; l++) begin
                r_sum[l] <= '0;
            end
            for (int m = 0; m < MARKS; m++) begin
                r_cnt[m] <= '0;
            end
        end else if (i_cmd.acc_en) begin
            for (int l = 0; l < LANES; l++) begin
                if (hit[l/2]) begin
                    r_sum[l] <= r_sum[l] + cmc_pkg::SUM_W'(lane_pos[l]);
                end
            end
            for (int m = 0; m < MARKS; m++) begin
                if (hit[m]) begin
                    r_cnt[m] <= r_cnt[m] + 1'b1;
                end
            end
        end
    end

    // Trial subtraction compare for each lane.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            ge[l] = ({1'b0, r_rem[l]} >= (cmc_pkg::SUM_W+1)'(r_dvs[l/2]));
        end
    end

    // Restoring division, one quotient bit per step, most significant first.
    // A quotient above the mean range is flagged at load and saturates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int l = 0; l < LANES; l++) begin
                r_rem[l] <= r_sum[l];
                r_quo[l] <= '0;
                r_sat[l] <= ({1'b0, r_sum[l]} >=
                             {r_cnt[l/2], {cmc_pkg::DIV_STEPS{1'b0}}});
            end
            for (int m = 0; m < MARKS; m++) begin
                r_dvs[m]   <= {r_cnt[m], {(cmc_pkg::DIV_STEPS-1){1'b0}}};
                r_found[m] <= (r_cnt[m] != '0);
            end
        end else if (i_cmd.step) begin
            for (int l = 0; l < LANES; l++) begin
                if (ge[l]) begin
                    r_rem[l] <= r_rem[l] - cmc_pkg::SUM_W'(r_dvs[l/2]);
                end
                r_quo[l] <= {r_quo[l][cmc_pkg::POS_W-2:0], ge[l]};
            end
            for (int m = 0; m < MARKS; m++) begin
                r_dvs[m] <= r_dvs[m] >> 1;
            end
        end
    end

    // Final mean per lane: zero when the marker was not seen, all ones when saturated.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (!r_found[l/2]) begin
                mean[l] = '0;
            end else if (r_sat[l]) begin
                mean[l] = '1;
            end else begin
                mean[l] = r_quo[l];
            end
        end
    end

    // Output register: holds a result until the transaction completes.
    assign o_status.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            for (int l = 0; l < LANES; l++) begin
                r_out_mean[l] <= mean[l];
            end
            for (int m = 0; m < MARKS; m++) begin
                r_out_found[m] <= r_found[m];
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_start_row   = r_out_mean[0];
    assign o_start_col   = r_out_mean[1];
    assign o_start_found = r_out_found[0];
    assign o_end_row     = r_out_mean[2];
    assign o_end_col     = r_out_mean[3];
    assign o_end_found   = r_out_found[1];

endmodule

### src/color_marker_centroid_unit.sv
// ----------------------------------------------------------------------------
// Color marker centroid unit
// Classifies a BGR pixel raster into start and end markers and reports the
// truncated centroid of each marker class at the end of every frame.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle within a frame. After a pixel marked last
// the input stalls while the dividers are loaded, 8 restoring steps (one
// mean bit each) run and the result is published to the output register.
// The stall lasts longer, and the result is offered later, only while the
// previous result is still stalled in the output register.
// Synchronous active-low reset clears sums, counts and output valid; dark limit 50, bright 200.
module color_marker_centroid_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cmc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cmc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cmc_pkg::CHAN_W-1:0]        i_blue,
    input  logic [cmc_pkg::CHAN_W-1:0]        i_green,
    input  logic [cmc_pkg::CHAN_W-1:0]        i_red,
    input  logic [cmc_pkg::POS_W-1:0]         i_row,
    input  logic [cmc_pkg::POS_W-1:0]         i_col,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cmc_pkg::POS_W-1:0]         o_start_row,
    output logic [cmc_pkg::POS_W-1:0]         o_start_col,
    output logic                              o_start_found,
    output logic [cmc_pkg::POS_W-1:0]         o_end_row,
    output logic [cmc_pkg::POS_W-1:0]         o_end_col,
    output logic                              o_end_found
);

    cmc_pkg::t_ctrl_cmd  cmd;
    cmc_pkg::t_dp_status status;

    // Frame sequencing.
    cmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Accumulation, division and output register.
    cmc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_blue        (i_blue),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_start_row   (o_start_row),
        .o_start_col   (o_start_col),
        .o_start_found (o_start_found),
        .o_end_row     (o_end_row),
        .o_end_col     (o_end_col),
        .o_end_found   (o_end_found)
    );

endmodule

### src/cmc_checker.sv
// ----------------------------------------------------------------------------
// Color marker centroid checker
// Port-level assertions on the centroid unit, attached by bind.
// ----------------------------------------------------------------------------
module cmc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic                              i_last,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [cmc_pkg::POS_W-1:0]         o_start_row,
    input  logic [cmc_pkg::POS_W-1:0]         o_start_col,
    input  logic                              o_start_found,
    input  logic [cmc_pkg::POS_W-1:0]         o_end_row,
    input  logic [cmc_pkg::POS_W-1:0]         o_end_col,
    input  logic                              o_end_found
);

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_start_row) &&
            $stable(o_start_col) && $stable(o_start_found) &&
            $stable(o_end_row) && $stable(o_end_col) && $stable(o_end_found))
        else $error("stalled result changed");

    // A missing start marker reports a zero centroid.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_start_found |-> o_start_row == '0 && o_start_col == '0)
        else $error("start centroid nonzero without marker");

    // A missing end marker reports a zero centroid.
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_found |-> o_end_row == '0 && o_end_col == '0)
        else $error("end centroid nonzero without marker");

    // The input pauses while a finished frame is being divided.
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("pixel taken during mean division");

endmodule

bind color_marker_centroid_unit cmc_checker u_cmc_checker (.*);
